// ----- hw/rtl/mvsm_pkg.sv -----
// Package for the multi-voice sample mixer: sizes, opcodes and status codes.
// Used by the mixer top level; depends on nothing.
package mvsm_pkg;
	localparam int VoiceCount = 32;
	localparam int VoiceSamples = 4096;
	localparam int GainFracBits = 12;
	localparam int VoiceW = 5;
	localparam int IdxW = 12;
	localparam int LenW = 13;
	localparam int AddrW = VoiceW + IdxW;
	localparam int MemDepth = VoiceCount * VoiceSamples;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_LOAD = 3'd1,
		OP_PLAY = 3'd2,
		OP_STOP = 3'd3,
		OP_GAIN = 3'd4,
		OP_FREE = 3'd5,
		OP_MIX = 3'd6,
		OP_ENDBUF = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_IGNORED = 2'd1,
		ST_DISABLED = 2'd2
	} status_t;
endpackage

// ----- hw/rtl/multi_voice_sample_mixer.sv -----
// Top level of the multi-voice sample mixer: command decode, voice tables,
// sample memory and the shared multiply-accumulate sequencer. Uses mvsm_pkg.
//
// Usage: a command is transferred at a clock edge where start is high and busy
// is low. Its single result appears on mixed_sample and status for exactly one
// cycle with done high; the receiver cannot stall it.
// Voice commands (write, load, play, stop, gain, free) go from the command state
// straight to the output state. An enabled mix command walks the 32 voices through
// one memory read port and one 16x16 multiplier: one voice per cycle, each read
// registered before it is accumulated. An enabled end-of-buffer command walks the
// voices one per cycle. busy is high from transfer to result.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) sets the mixer
// enable; it is always ready and should be written only while idle.
// Reset clears all voice tables and the enable at once; sample memory has no
// reset and must be written before a playing voice reads it.
module multi_voice_sample_mixer (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] opcode,
	input logic [mvsm_pkg::VoiceW-1:0] voice,
	input logic [mvsm_pkg::IdxW-1:0] sample_index,
	input logic signed [15:0] sample_value,
	input logic [mvsm_pkg::LenW-1:0] voice_length,
	input logic loop_flag,
	input logic [15:0] gain,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data,
	output logic done,
	output logic signed [15:0] mixed_sample,
	output logic [1:0] status
);
	import mvsm_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CMD, S_MIX, S_ENDB, S_OUT} state_t;

	state_t state_q;
	logic enabled_q;
	logic [LenW-1:0] len_q [VoiceCount];
	logic [LenW-1:0] pos_q [VoiceCount];
	logic [15:0] gain_q [VoiceCount];
	logic [VoiceCount-1:0] playing_q, looping_q, loaded_q;
	logic [15:0] mem [MemDepth];
	logic [15:0] rd_q;

	opcode_t op_q;
	logic [VoiceW-1:0] v_q;
	logic [IdxW-1:0] idx_q;
	logic [15:0] val_q;
	logic [LenW-1:0] vlen_q;
	logic loop_q;
	logic [15:0] g_q;

	// Voice index issued for the read, and the one whose data is in rd_q.
	logic [VoiceW:0] rv_q;
	logic [VoiceW-1:0] av_q;
	logic act_q;
	logic signed [15:0] sum_q;
	logic signed [15:0] res_q;
	logic [1:0] st_q;

	logic [VoiceW-1:0] rv;
	logic rd_ok;
	logic signed [32:0] prod;
	logic signed [32:0] scaled;
	logic signed [33:0] acc;
	logic signed [15:0] acc_sat;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign rv = rv_q[VoiceW-1:0];
	assign rd_ok = loaded_q[rv] && playing_q[rv] && (pos_q[rv] < len_q[rv]);

	// Product of the latched sample and gain; truncate toward zero on the shift.
	assign prod = $signed(rd_q) * $signed({1'b0, gain_q[av_q]});
	assign scaled = (prod < 0)
		? -((-prod) >>> GainFracBits) : (prod >>> GainFracBits);
	assign acc = 34'(sum_q) + 34'(scaled);
	assign acc_sat = (acc > 34'sd32767) ? 16'sh7fff
		: (acc < -34'sd32768) ? 16'sh8000 : acc[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enabled_q <= cfg_data;
		end
	end

	// Sample memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == S_CMD && op_q == OP_WRITE) begin
			mem[{v_q, idx_q}] <= val_q;
		end
		rd_q <= mem[{rv, pos_q[rv][IdxW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= opcode_t'(opcode);
			v_q <= voice;
			idx_q <= sample_index;
			val_q <= sample_value;
			vlen_q <= voice_length;
			loop_q <= loop_flag;
			g_q <= gain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			playing_q <= '0;
			looping_q <= '0;
			loaded_q <= '0;
			for (int i = 0; i < VoiceCount; i++) begin
				len_q[i] <= '0;
				pos_q[i] <= '0;
				gain_q[i] <= '0;
			end
			rv_q <= '0;
			av_q <= '0;
			act_q <= 1'b0;
			sum_q <= '0;
			res_q <= '0;
			st_q <= ST_DONE;
			done <= 1'b0;
			mixed_sample <= '0;
			status <= ST_DONE;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					res_q <= '0;
					st_q <= ST_DONE;
					rv_q <= '0;
					act_q <= 1'b0;
					sum_q <= '0;
					state_q <= S_OUT;
					if (op_q == OP_MIX || op_q == OP_ENDBUF) begin
						if (!enabled_q) begin
							st_q <= ST_DISABLED;
						end else begin
							state_q <= (op_q == OP_MIX) ? S_MIX : S_ENDB;
						end
					end else begin
						unique case (op_q)
							OP_LOAD: begin
								len_q[v_q] <= (vlen_q > LenW'(VoiceSamples))
									? LenW'(VoiceSamples) : vlen_q;
								pos_q[v_q] <= '0;
								playing_q[v_q] <= 1'b0;
								looping_q[v_q] <= 1'b0;
								gain_q[v_q] <= 16'(1 << GainFracBits);
								loaded_q[v_q] <= 1'b1;
							end
							OP_PLAY: begin
								if (!loaded_q[v_q]) begin
									st_q <= ST_IGNORED;
								end else begin
									pos_q[v_q] <= '0;
									playing_q[v_q] <= 1'b1;
									looping_q[v_q] <= loop_q;
								end
							end
							OP_STOP: playing_q[v_q] <= 1'b0;
							OP_GAIN: gain_q[v_q] <= g_q;
							OP_FREE: begin
								loaded_q[v_q] <= 1'b0;
								playing_q[v_q] <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_MIX: begin
					// Accumulate the voice read last cycle while reading the next.
					if (act_q) begin
						sum_q <= acc_sat;
					end
					if (rv_q == (VoiceW+1)'(VoiceCount)) begin
						act_q <= 1'b0;
						res_q <= act_q ? acc_sat : sum_q;
						state_q <= S_OUT;
					end else begin
						act_q <= rd_ok;
						av_q <= rv;
						if (rd_ok) begin
							pos_q[rv] <= pos_q[rv] + 1'b1;
						end
						rv_q <= rv_q + 1'b1;
					end
				end
				S_ENDB: begin
					if (loaded_q[rv] && playing_q[rv] && pos_q[rv] >= len_q[rv]) begin
						if (looping_q[rv]) begin
							pos_q[rv] <= '0;
						end else begin
							playing_q[rv] <= 1'b0;
						end
					end
					if (rv_q == (VoiceW+1)'(VoiceCount-1)) begin
						state_q <= S_OUT;
					end
					rv_q <= rv_q + 1'b1;
				end
				S_OUT: begin
					done <= 1'b1;
					mixed_sample <= res_q;
					status <= st_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_DONE |-> mixed_sample == 16'sd0)
		else $error("nonzero mix with a non-done status");
`endif
endmodule
